### design/egcd_pkg.sv
// Shared constants and types for the extended GCD block.
// Used by the channel interfaces, the divider and the top level; no dependencies.
package egcd_pkg;

	// Operand width and the width of the signed Bezout coefficients.
	localparam int OPND_W = 32;
	localparam int COEF_W = OPND_W + 1;

	// Step counter of the divider: counts OPND_W - 1 down to zero.
	localparam int CNT_W = $clog2(OPND_W);

	// Divider control from the sequencer.
	typedef struct packed {
		logic start;
	} div_ctrl_t;

	// Divider status to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### design/egcd_in_if.sv
// Operand channel of the extended GCD block: valid/ready handshake and two operands.
// Depends on egcd_pkg for the operand width.
interface egcd_in_if;
	logic                        valid;
	logic                        ready;
	logic [egcd_pkg::OPND_W-1:0] x_value;
	logic [egcd_pkg::OPND_W-1:0] y_value;

	modport source (output valid, output x_value, output y_value, input ready);
	modport sink   (input valid, input x_value, input y_value, output ready);
endinterface

### design/egcd_out_if.sv
// Result channel of the extended GCD block: valid/ready handshake, gcd and coefficients.
// Depends on egcd_pkg for the operand and coefficient widths.
interface egcd_out_if;
	logic                               valid;
	logic                               ready;
	logic        [egcd_pkg::OPND_W-1:0] gcd_value;
	logic signed [egcd_pkg::COEF_W-1:0] coef_x;
	logic signed [egcd_pkg::COEF_W-1:0] coef_y;

	modport source (output valid, output gcd_value, output coef_x, output coef_y, input ready);
	modport sink   (input valid, input gcd_value, input coef_x, input coef_y, output ready);
endinterface

### design/extended_gcd.sv
// Extended GCD: one Euclid step per division of the bit-serial divider, repeated until
// the second remainder is zero.
// One item is in work at a time; the bit-serial divider sets the step length.
// A finished result waits in an output register while the next item is taken.
// Reset (arst_n, asynchronous) empties the sequencer and the output register.
// Depends on egcd_pkg, egcd_in_if, egcd_out_if and egcd_divider.
module extended_gcd (
	input  logic       clk,
	input  logic       arst_n,
	egcd_in_if.sink    operands,
	egcd_out_if.source result
);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;

	logic [1:0] state_q;

	// Working remainders and Bezout coefficients. The invariants are
	// rx = ca*x + cb*y and ry = cc*x + cd*y, all coefficients modulo 2^COEF_W.
	logic [egcd_pkg::OPND_W-1:0] rx_q;
	logic [egcd_pkg::OPND_W-1:0] ry_q;
	logic [egcd_pkg::COEF_W-1:0] ca_q;
	logic [egcd_pkg::COEF_W-1:0] cb_q;
	logic [egcd_pkg::COEF_W-1:0] cc_q;
	logic [egcd_pkg::COEF_W-1:0] cd_q;

	// Output register.
	logic                        out_valid_q;
	logic [egcd_pkg::OPND_W-1:0] gcd_q;
	logic [egcd_pkg::COEF_W-1:0] coef_x_q;
	logic [egcd_pkg::COEF_W-1:0] coef_y_q;

	egcd_pkg::div_ctrl_t         div_ctrl;
	egcd_pkg::div_stat_t         div_stat;
	logic [egcd_pkg::OPND_W-1:0] div_rem;
	logic [egcd_pkg::COEF_W-1:0] prod_c;
	logic [egcd_pkg::COEF_W-1:0] prod_d;

	logic in_fire;
	logic finish;

	assign operands.ready = (state_q == ST_IDLE);
	assign in_fire        = operands.valid && operands.ready;

	// The recurrence ends when the second remainder is zero. The result is only
	// written once the output register is free or being emptied in this cycle.
	assign finish = (state_q == ST_CHECK) && (ry_q == '0) &&
		(!out_valid_q || result.ready);

	// In the check state, a new division starts whenever the second remainder is still nonzero.
	assign div_ctrl.start = (state_q == ST_CHECK) && (ry_q != '0);

	egcd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (rx_q),
		.divisor  (ry_q),
		.coef_c   (cc_q),
		.coef_d   (cd_q),
		.stat     (div_stat),
		.remainder(div_rem),
		.prod_c   (prod_c),
		.prod_d   (prod_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (div_ctrl.start) begin
						state_q <= ST_DIV;
					end else if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_CHECK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Load the operands, then apply one Euclid step per finished division:
	// (rx, ry) <- (ry, rx mod ry) and (ca, cc) <- (cc, ca - q*cc), same for cb, cd.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rx_q <= operands.x_value;
			ry_q <= operands.y_value;
			ca_q <= egcd_pkg::COEF_W'(1);
			cb_q <= '0;
			cc_q <= '0;
			cd_q <= egcd_pkg::COEF_W'(1);
		end else if (state_q == ST_DIV && div_stat.done) begin
			rx_q <= ry_q;
			ry_q <= div_rem;
			ca_q <= cc_q;
			cc_q <= ca_q - prod_c;
			cb_q <= cd_q;
			cd_q <= cb_q - prod_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !result.ready) || finish;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			gcd_q    <= rx_q;
			coef_x_q <= ca_q;
			coef_y_q <= cb_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.gcd_value = gcd_q;
	assign result.coef_x    = coef_x_q;
	assign result.coef_y    = coef_y_q;

endmodule

### design/egcd_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle, that also forms
// quotient * coefficient for two coefficients by Horner accumulation. Uses egcd_pkg.
module egcd_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  egcd_pkg::div_ctrl_t         ctrl,
	input  logic [egcd_pkg::OPND_W-1:0] dividend,
	input  logic [egcd_pkg::OPND_W-1:0] divisor,
	input  logic [egcd_pkg::COEF_W-1:0] coef_c,
	input  logic [egcd_pkg::COEF_W-1:0] coef_d,
	output egcd_pkg::div_stat_t         stat,
	output logic [egcd_pkg::OPND_W-1:0] remainder,
	output logic [egcd_pkg::COEF_W-1:0] prod_c,
	output logic [egcd_pkg::COEF_W-1:0] prod_d
);

	logic                        busy_q;
	logic                        done_q;
	logic [egcd_pkg::CNT_W-1:0]  cnt_q;
	logic [egcd_pkg::OPND_W-1:0] rem_q;
	logic [egcd_pkg::OPND_W-1:0] quo_q;
	logic [egcd_pkg::COEF_W-1:0] pc_q;
	logic [egcd_pkg::COEF_W-1:0] pd_q;

	logic [egcd_pkg::OPND_W:0]   partial;
	logic [egcd_pkg::OPND_W+1:0] diff;
	logic                        qbit;
	logic [egcd_pkg::OPND_W-1:0] rem_next;

	// Bring down the next dividend bit and try to subtract the divisor.
	always_comb begin
		partial  = {rem_q, quo_q[egcd_pkg::OPND_W-1]};
		diff     = {1'b0, partial} - {2'b00, divisor};
		qbit     = ~diff[egcd_pkg::OPND_W+1];
		rem_next = qbit ? diff[egcd_pkg::OPND_W-1:0] : partial[egcd_pkg::OPND_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			cnt_q <= egcd_pkg::CNT_W'(egcd_pkg::OPND_W - 1);
			rem_q <= '0;
			quo_q <= dividend;
			pc_q  <= '0;
			pd_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			rem_q <= rem_next;
			quo_q <= {quo_q[egcd_pkg::OPND_W-2:0], 1'b0};
			// Products are kept modulo 2^COEF_W, which is all the result needs.
			pc_q  <= {pc_q[egcd_pkg::COEF_W-2:0], 1'b0} + (qbit ? coef_c : '0);
			pd_q  <= {pd_q[egcd_pkg::COEF_W-2:0], 1'b0} + (qbit ? coef_d : '0);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;
	assign prod_c    = pc_q;
	assign prod_d    = pd_q;

endmodule

### bench/egcd_result_monitor.sv
// Watches the operand and result channels of extended_gcd, predicts each gcd and its
// Bezout coefficients from the operands, and compares every result field by field.
// Depends on egcd_pkg, egcd_in_if and egcd_out_if.
module egcd_result_monitor (
	input  logic clk,
	input  logic arst_n,
	egcd_in_if   operands,
	egcd_out_if  result,
	output int   fail_count,
	output int   checked_count,
	output int   pending_count
);

	typedef struct packed {
		logic        [egcd_pkg::OPND_W-1:0] x;
		logic        [egcd_pkg::OPND_W-1:0] y;
		logic        [egcd_pkg::OPND_W-1:0] gcd;
		logic signed [egcd_pkg::COEF_W-1:0] coef_x;
		logic signed [egcd_pkg::COEF_W-1:0] coef_y;
	} bezout_t;

	bezout_t pending_bezout[$];
	int      n_fail;
	int      n_checked;

	// Euclid's recurrence with the coefficient pairs carried modulo 2^64. The true
	// values fit in COEF_W signed bits, so the low bits are exact.
	function automatic bezout_t bezout_of(input logic [egcd_pkg::OPND_W-1:0] x,
		input logic [egcd_pkg::OPND_W-1:0] y);
		logic [63:0] r_hi, r_lo, quo, rem, s_cur, s_nxt, t_cur, t_nxt, hold;
		bezout_t     b;
		r_hi  = 64'(x);
		r_lo  = 64'(y);
		s_cur = 64'd1;
		t_cur = 64'd0;
		s_nxt = 64'd0;
		t_nxt = 64'd1;
		while (r_lo != 64'd0) begin
			quo   = r_hi / r_lo;
			rem   = r_hi % r_lo;
			r_hi  = r_lo;
			r_lo  = rem;
			hold  = s_nxt;
			s_nxt = s_cur - quo * s_nxt;
			s_cur = hold;
			hold  = t_nxt;
			t_nxt = t_cur - quo * t_nxt;
			t_cur = hold;
		end
		b.x      = x;
		b.y      = y;
		b.gcd    = r_hi[egcd_pkg::OPND_W-1:0];
		b.coef_x = s_cur[egcd_pkg::COEF_W-1:0];
		b.coef_y = t_cur[egcd_pkg::COEF_W-1:0];
		return b;
	endfunction

	task automatic report_mismatch(input string msg);
		n_fail++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		bezout_t exp_b;
		if (arst_n) begin
			// Results are matched before operands are queued: a result can never
			// belong to operands taken at the same edge.
			if (result.valid && result.ready) begin
				if (pending_bezout.size() == 0) begin
					report_mismatch($sformatf("unexpected result gcd=%0d coef_x=%0d coef_y=%0d",
						result.gcd_value, result.coef_x, result.coef_y));
				end else begin
					exp_b = pending_bezout.pop_front();
					n_checked++;
					if (result.gcd_value !== exp_b.gcd) begin
						report_mismatch($sformatf("x=%0d y=%0d gcd %0d, expected %0d",
							exp_b.x, exp_b.y, result.gcd_value, exp_b.gcd));
					end
					if (result.coef_x !== exp_b.coef_x) begin
						report_mismatch($sformatf("x=%0d y=%0d coef_x %0d, expected %0d",
							exp_b.x, exp_b.y, result.coef_x, exp_b.coef_x));
					end
					if (result.coef_y !== exp_b.coef_y) begin
						report_mismatch($sformatf("x=%0d y=%0d coef_y %0d, expected %0d",
							exp_b.x, exp_b.y, result.coef_y, exp_b.coef_y));
					end
				end
			end
			if (operands.valid && operands.ready) begin
				pending_bezout.push_back(bezout_of(operands.x_value, operands.y_value));
			end
		end
		fail_count    <= n_fail;
		checked_count <= n_checked;
		pending_count <= pending_bezout.size();
	end

endmodule

### bench/extended_gcd_tb.sv
// Top of the extended_gcd testbench: clock, reset, operand stimulus and result back-pressure.
// Checking is done by egcd_result_monitor; depends on egcd_pkg, egcd_in_if and egcd_out_if.
module extended_gcd_tb;

	// Slowest correct run: about 425 items, each a full chain of Euclid steps plus
	// the longest sender gap and receiver stall. The limit is set well above that.
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int RANDOM_ITEMS = 400;
	// One worst-case item, used as the quiet period after the last result.
	localparam int DRAIN_CYCLES = 2000;

	logic clk;
	logic arst_n;

	egcd_in_if  operands_if ();
	egcd_out_if result_if ();

	extended_gcd u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands_if),
		.result   (result_if)
	);

	int fail_count;
	int checked_count;
	int pending_count;

	egcd_result_monitor u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.operands      (operands_if),
		.result        (result_if),
		.fail_count    (fail_count),
		.checked_count (checked_count),
		.pending_count (pending_count)
	);

	// Bookkeeping for the summary.
	int n_sent;
	int n_high;
	int n_zero;

	// Number of upcoming transfers sent back to back, with no gap at all.
	int burst_left;

	// Consecutive Fibonacci numbers are the slowest operand pairs for Euclid:
	// every quotient is one, so the step count is as large as the width allows.
	logic [egcd_pkg::OPND_W-1:0] fib[0:47];

	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, pending_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result back-pressure. Most of the time ready stays high; now and then a short
	// stall, rarely a long one, and every so often a long calm stretch with no stalls.
	initial begin
		int stall_left;
		int calm_left;
		int pick;
		stall_left = 0;
		calm_left  = 0;
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm_left > 0) begin
				calm_left--;
				result_if.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					stall_left = $urandom_range(20, 120);
				end else if (pick < 25) begin
					stall_left = $urandom_range(1, 3);
				end else if (pick < 27) begin
					calm_left = $urandom_range(200, 1500);
				end
			end
		end
	end

	// Gap after an operand transfer: mostly none or short, a few long ones, and
	// occasional bursts where a run of items goes back to back.
	function automatic int pick_gap();
		int pick;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			burst_left = $urandom_range(4, 20);
			return 0;
		end else if (pick < 55) begin
			return 0;
		end else if (pick < 88) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 150);
	endfunction

	// Offers one operand pair and holds it until the block takes it. Returns at the
	// falling edge where the next pair may be driven. Valid is only lowered when a
	// gap follows, so it never drops and rises again within one time step.
	task automatic send_pair(input logic [egcd_pkg::OPND_W-1:0] x,
		input logic [egcd_pkg::OPND_W-1:0] y);
		int gap;
		operands_if.valid   <= 1'b1;
		operands_if.x_value <= x;
		operands_if.y_value <= y;
		do begin
			@(posedge clk);
		end while (!operands_if.ready);
		@(negedge clk);
		n_sent++;
		if (x[egcd_pkg::OPND_W-1] || y[egcd_pkg::OPND_W-1]) begin
			n_high++;
		end
		if (x == '0 || y == '0) begin
			n_zero++;
		end
		gap = pick_gap();
		if (gap > 0) begin
			operands_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Random operand pairs. Plain uniform operands give short Euclid chains, so
	// a good share of the mix is shaped: small values, a common factor, Fibonacci
	// neighbors, divisibility, operands with the top bit set and random bit lengths.
	task automatic random_pair(output logic [egcd_pkg::OPND_W-1:0] x,
		output logic [egcd_pkg::OPND_W-1:0] y);
		int                          pick;
		int                          k;
		logic [egcd_pkg::OPND_W-1:0] g;
		logic [egcd_pkg::OPND_W-1:0] swap;
		pick = $urandom_range(0, 99);
		x = $urandom();
		y = $urandom();
		if (pick < 30) begin
			// Uniform operands, left as drawn.
		end else if (pick < 42) begin
			x = $urandom_range(0, 255);
			y = $urandom_range(0, 255);
		end else if (pick < 57) begin
			g = $urandom_range(1, 65535);
			x = g * egcd_pkg::OPND_W'($urandom_range(0, 65535));
			y = g * egcd_pkg::OPND_W'($urandom_range(0, 65535));
		end else if (pick < 67) begin
			k = $urandom_range(1, 46);
			x = fib[k + 1];
			y = fib[k];
			if ($urandom_range(0, 1) == 1) begin
				swap = x;
				x    = y;
				y    = swap;
			end
		end else if (pick < 77) begin
			// One operand a multiple of the other, equal, or zero.
			y = $urandom_range(0, 70000);
			case ($urandom_range(0, 3))
				0: x = y * egcd_pkg::OPND_W'($urandom_range(0, 60000));
				1: x = y;
				2: x = '0;
				default: begin
					x = y;
					y = '0;
				end
			endcase
		end else if (pick < 87) begin
			x[egcd_pkg::OPND_W-1] = 1'b1;
			y[egcd_pkg::OPND_W-1] = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 1) == 1) begin
				swap = x;
				x    = y;
				y    = swap;
			end
		end else begin
			x = x >> $urandom_range(0, egcd_pkg::OPND_W - 1);
			y = y >> $urandom_range(0, egcd_pkg::OPND_W - 1);
		end
	endtask

	initial begin
		logic [egcd_pkg::OPND_W-1:0] rx;
		logic [egcd_pkg::OPND_W-1:0] ry;
		int                          i;

		fib[0] = '0;
		fib[1] = 1;
		for (i = 2; i < 48; i++) begin
			fib[i] = fib[i - 1] + fib[i - 2];
		end

		n_sent      = 0;
		n_high      = 0;
		n_zero      = 0;
		burst_left  = 0;

		operands_if.valid   = 1'b0;
		operands_if.x_value = '0;
		operands_if.y_value = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pairs: the zero-operand special cases, all-ones extremes, values
		// at and above 2^31 that a signed division would get wrong, the longest
		// Fibonacci chain in both orders, primes and a few small textbook cases.
		send_pair('0, '0);
		send_pair(32'd123, '0);
		send_pair('0, 32'd456);
		send_pair('0, '1);
		send_pair('1, '0);
		send_pair(32'd1, 32'd1);
		send_pair('1, '1);
		send_pair('1, 32'd1);
		send_pair(32'd1, '1);
		send_pair('1, 32'hFFFF_FFFE);
		send_pair(32'hFFFF_FFFE, '1);
		send_pair(32'h8000_0000, 32'h7FFF_FFFF);
		send_pair(32'h8000_0000, 32'h8000_0000);
		send_pair(32'h8000_0000, 32'd3);
		send_pair(32'd3, 32'h8000_0000);
		send_pair(fib[47], fib[46]);
		send_pair(fib[46], fib[47]);
		send_pair(32'd4294967291, 32'd4294967279);
		send_pair(32'd12, 32'd18);
		send_pair(32'd240, 32'd46);
		send_pair(32'h0010_0000, 32'h0000_1000);
		send_pair(32'hAAAA_AAAA, 32'h5555_5555);
		send_pair(32'hFFFF_0000, 32'h0000_FFFF);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			random_pair(rx, ry);
			send_pair(rx, ry);
		end
		operands_if.valid <= 1'b0;

		// Let every expected result arrive, then watch a while longer for strays.
		while (pending_count != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d operand pairs sent (%0d with a zero operand, %0d at or above 2^31),",
			n_sent, n_zero, n_high);
		$display("%0d results compared, %0d mismatches, %0d cycles", checked_count,
			fail_count, cycle_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
